// ===== src/mbet_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
// Used by every module of the block; depends on nothing.
package mbet_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS     = 28;
  localparam int PIXEL_BITS    = 12;
  localparam int STEP_BITS     = 31;
  localparam int LIMIT_BITS    = 16;
  localparam int PAL_BITS      = 16;
  localparam int COLOR_BITS    = 17;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam int PPROD_BITS = PIXEL_BITS + STEP_BITS;
  localparam int WIDE_BITS  = PPROD_BITS + 2;
  localparam int MAG_BITS   = FRAC_BITS + 2;
  localparam int SQP_BITS   = 2 * MAG_BITS;
  localparam int SQ_BITS    = SQP_BITS - FRAC_BITS;
  localparam int CROSS_BITS = SQ_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [COORD_BITS-1:0]        mag_t;

  localparam mag_t  TWO_Q  = COORD_BITS'(64'd2 << FRAC_BITS);
  localparam logic [SQ_BITS:0] FOUR_Q = (SQ_BITS + 1)'(64'd4 << FRAC_BITS);
  localparam wide_t CMAX_W = WIDE_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);

  localparam coord_t RST_ORIGIN_RE = -32'sd536870912;
  localparam coord_t RST_TOP_IM    = 32'sd402653184;
  localparam logic [STEP_BITS-1:0]  RST_STEP    = STEP_BITS'(262144);
  localparam logic [LIMIT_BITS-1:0] RST_LIMIT   = LIMIT_BITS'(256);
  localparam logic [PAL_BITS-1:0]   RST_PALETTE = PAL_BITS'(256);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_RE       = 3'd0,
    REG_TOP_IM          = 3'd1,
    REG_STEP_RE         = 3'd2,
    REG_STEP_IM         = 3'd3,
    REG_ITERATION_LIMIT = 3'd4,
    REG_COLORING_MODE   = 3'd5,
    REG_PALETTE_SIZE    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_ADD,
    CS_DONE
  } core_state_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;
  } pix_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] col_out;
    logic [PIXEL_BITS-1:0] row_out;
    logic [COLOR_BITS-1:0] color_index;
    logic                  in_set;
  } res_t;

  typedef struct packed {
    coord_t                 origin_re;
    coord_t                 top_im;
    logic [STEP_BITS-1:0]   step_re;
    logic [STEP_BITS-1:0]   step_im;
    logic [LIMIT_BITS-1:0]  iteration_limit;
    logic                   coloring_mode;
    logic [PAL_BITS-1:0]    palette_size;
  } cfg_t;

  typedef struct packed {
    pix_t   pos;
    coord_t cr;
    coord_t ci;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic wide_t widen(input coord_t v);
    widen = {{(WIDE_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic coord_t sat_coord(input wide_t v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WIDE_BITS-1:COORD_BITS-1];
    hi_zeros = ~|v[WIDE_BITS-1:COORD_BITS-1];
    if (hi_ones || hi_zeros) begin
      sat_coord = v[COORD_BITS-1:0];
    end else if (v[WIDE_BITS-1]) begin
      sat_coord = {1'b1, {(COORD_BITS - 1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_BITS - 1){1'b1}}};
    end
  endfunction

  function automatic mag_t mag_of(input coord_t v);
    coord_t neg;
    neg = -v;
    mag_of = v[COORD_BITS-1] ? mag_t'(neg) : mag_t'(v);
  endfunction

endpackage

// ===== src/mbet_front.sv =====
// Front end: takes pixel requests, scales the position by the step registers
// and forms the saturated point c. Depends on mbet_pkg.
module mbet_front import mbet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pix_valid,
  input  pix_t   pix,
  output logic   pix_stall,
  input  qstat_t qstat,
  output logic   q_push,
  output qent_t  q_wdata
);

  logic                  f_valid;
  pix_t                  f_pos;
  logic [PPROD_BITS-1:0] prod_re;
  logic [PPROD_BITS-1:0] prod_im;
  logic                  take;

  assign q_push    = f_valid && !qstat.full;
  assign pix_stall = f_valid && qstat.full;
  assign take      = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_pos   <= pix;
      prod_re <= pix.pixel_col * cfg.step_re;
      prod_im <= pix.pixel_row * cfg.step_im;
    end
  end

  always_comb begin
    q_wdata.pos = f_pos;
    q_wdata.cr  = sat_coord(widen(cfg.origin_re) + wide_t'({2'b00, prod_re}));
    q_wdata.ci  = sat_coord(widen(cfg.top_im) - wide_t'({2'b00, prod_im}));
  end

endmodule

// ===== src/mbet_queue.sv =====
// Short FIFO of formed points between the front end and the iteration core.
// Depends on mbet_pkg.
module mbet_queue import mbet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qent_t  wdata,
  input  logic   pop,
  output qent_t  rdata,
  output qstat_t stat
);

  qent_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/mbet_core.sv =====
// Iteration core: runs z = z^2 + c on one point at a time (multiply state, then
// add state) and holds the finished result in an output register. Depends on mbet_pkg.
module mbet_core import mbet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  qstat_t qstat,
  input  qent_t  q_rdata,
  output logic   q_pop,
  output logic   res_valid,
  input  logic   res_stall,
  output res_t   res
);

  core_state_t             state;
  core_state_t             state_next;
  pix_t                    pos;
  coord_t                  cr;
  coord_t                  ci;
  coord_t                  zr;
  coord_t                  zi;
  logic [LIMIT_BITS-1:0]   n;
  logic                    bounded;
  logic [SQP_BITS-1:0]     p_rr;
  logic [SQP_BITS-1:0]     p_ii;
  logic [SQP_BITS-1:0]     p_ri;

  mag_t                    ar;
  mag_t                    ai;
  logic [MAG_BITS-1:0]     ar_m;
  logic [MAG_BITS-1:0]     ai_m;
  logic                    lim_hit;
  logic                    esc_mag;
  logic [SQ_BITS-1:0]      r2;
  logic [SQ_BITS-1:0]      i2;
  logic [SQ_BITS:0]        sum2;
  logic                    esc_sum;
  logic [CROSS_BITS-1:0]   xprod;
  wide_t                   cross_w;
  wide_t                   term;
  coord_t                  diff;
  coord_t                  zr_next;
  coord_t                  zi_next;
  logic                    out_free;
  logic                    load_item;
  logic                    do_mul;
  logic                    step_z;
  logic                    fin_in;
  logic                    fin_out;
  logic                    emit;
  logic [PAL_BITS+1:0]     three_p;
  logic [PAL_BITS-1:0]     offset;
  logic [COLOR_BITS-1:0]   color;

  assign ar      = mag_of(zr);
  assign ai      = mag_of(zi);
  assign ar_m    = ar[MAG_BITS-1:0];
  assign ai_m    = ai[MAG_BITS-1:0];
  assign lim_hit = (n == cfg.iteration_limit);
  assign esc_mag = (ar > TWO_Q) || (ai > TWO_Q);

  assign r2      = p_rr[SQP_BITS-1:FRAC_BITS];
  assign i2      = p_ii[SQP_BITS-1:FRAC_BITS];
  assign sum2    = {1'b0, r2} + {1'b0, i2};
  assign esc_sum = (sum2 > FOUR_Q);
  assign xprod   = {p_ri[SQP_BITS-1:FRAC_BITS], 1'b0};
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    cross_w = {{(WIDE_BITS - CROSS_BITS){1'b0}}, xprod};
    if (cross_w > CMAX_W) begin
      cross_w = CMAX_W;
    end
    term    = (zr[COORD_BITS-1] != zi[COORD_BITS-1]) ? -cross_w : cross_w;
    zi_next = sat_coord(term + widen(ci));
    diff    = sat_coord(wide_t'({{(WIDE_BITS - SQ_BITS){1'b0}}, r2})
                        - wide_t'({{(WIDE_BITS - SQ_BITS){1'b0}}, i2}));
    zr_next = sat_coord(widen(diff) + widen(cr));
  end

  always_comb begin
    three_p = {2'b00, cfg.palette_size} + {1'b0, cfg.palette_size, 1'b0};
    if (!zr[COORD_BITS-1] && (zr != '0) && !zi[COORD_BITS-1] && (zi != '0)) begin
      offset = PAL_BITS'(1);
    end else if ((zr[COORD_BITS-1] || (zr == '0)) && !zi[COORD_BITS-1] && (zi != '0)) begin
      offset = {2'b00, cfg.palette_size[PAL_BITS-1:2]};
    end else if ((zr[COORD_BITS-1] || (zr == '0)) && zi[COORD_BITS-1]) begin
      offset = {1'b0, cfg.palette_size[PAL_BITS-1:1]};
    end else begin
      offset = three_p[PAL_BITS+1:2];
    end
    if (cfg.coloring_mode) begin
      color = {1'b0, n} + {1'b0, offset};
    end else begin
      color = {1'b0, n};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (!qstat.empty) begin
          state_next = CS_MUL;
        end
      end
      CS_MUL: begin
        if (lim_hit || esc_mag) begin
          state_next = CS_DONE;
        end else begin
          state_next = CS_ADD;
        end
      end
      CS_ADD: begin
        if (esc_sum) begin
          state_next = CS_DONE;
        end else begin
          state_next = CS_MUL;
        end
      end
      CS_DONE: begin
        if (out_free) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    load_item = 1'b0;
    do_mul    = 1'b0;
    step_z    = 1'b0;
    fin_in    = 1'b0;
    fin_out   = 1'b0;
    emit      = 1'b0;
    unique case (state)
      CS_IDLE: load_item = !qstat.empty;
      CS_MUL: begin
        priority if (lim_hit) begin
          fin_in = 1'b1;
        end else if (esc_mag) begin
          fin_out = 1'b1;
        end else begin
          do_mul = 1'b1;
        end
      end
      CS_ADD: begin
        if (esc_sum) begin
          fin_out = 1'b1;
        end else begin
          step_z = 1'b1;
        end
      end
      CS_DONE: emit = out_free;
      default: ;
    endcase
  end

  assign q_pop = load_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      pos <= q_rdata.pos;
      cr  <= q_rdata.cr;
      ci  <= q_rdata.ci;
      zr  <= q_rdata.cr;
      zi  <= q_rdata.ci;
      n   <= '0;
    end else if (step_z) begin
      zr  <= zr_next;
      zi  <= zi_next;
      n   <= n + 1'b1;
    end
    if (do_mul) begin
      p_rr <= ar_m * ar_m;
      p_ii <= ai_m * ai_m;
      p_ri <= ar_m * ai_m;
    end
    if (fin_in) begin
      bounded <= 1'b1;
    end else if (fin_out) begin
      bounded <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.col_out     <= pos.pixel_col;
      res.row_out     <= pos.pixel_row;
      res.color_index <= color;
      res.in_set      <= bounded;
    end
  end

endmodule

// ===== src/mandelbrot_escape_time_pixel.sv =====
// Top level of the Mandelbrot escape-time pixel block: configuration registers,
// front end, point queue and iteration core. Depends on mbet_pkg and its submodules.
//
// Usage:
//   Pixel requests (column, row) enter on pix_valid/pix_stall; one result per
//   request leaves on res_valid/res_stall in request order. A transfer happens
//   on a clock edge with valid high and stall low.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle; the user writes it only while no request is in flight, and the
//   block itself does not enforce this. Writes to index 7 are dropped.
//   Flow: the accepting edge registers the scaled position, the front end then
//   pushes c into the queue, and the idle core loads it. Each completed
//   iteration takes a multiply state, then the escape test and z update in
//   the add state; the last test ends in the multiply state when the limit is
//   hit or a component exceeds 2, or in the add state when |z|^2 > 4 ends it,
//   and the done state then fills the output register. The core takes one
//   pixel at a time while the front end and a 4-entry queue keep taking requests.
//   When the receiver stalls, the finished result holds in the output
//   register, the core waits with its next result, and the queue fills until
//   pix_stall rises. Reset empties all stages and restores register defaults.
module mandelbrot_escape_time_pixel import mbet_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     pix_valid,
  output logic                     pix_stall,
  input  pix_t                     pix,
  output logic                     res_valid,
  input  logic                     res_stall,
  output res_t                     res
);

  cfg_t   cfg;
  qstat_t qstat;
  logic   q_push;
  logic   q_pop;
  qent_t  q_wdata;
  qent_t  q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_re       <= RST_ORIGIN_RE;
      cfg.top_im          <= RST_TOP_IM;
      cfg.step_re         <= RST_STEP;
      cfg.step_im         <= RST_STEP;
      cfg.iteration_limit <= RST_LIMIT;
      cfg.coloring_mode   <= 1'b0;
      cfg.palette_size    <= RST_PALETTE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_RE:       cfg.origin_re       <= coord_t'(cfg_data);
        REG_TOP_IM:          cfg.top_im          <= coord_t'(cfg_data);
        REG_STEP_RE:         cfg.step_re         <= cfg_data[STEP_BITS-1:0];
        REG_STEP_IM:         cfg.step_im         <= cfg_data[STEP_BITS-1:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[LIMIT_BITS-1:0];
        REG_COLORING_MODE:   cfg.coloring_mode   <= cfg_data[0];
        REG_PALETTE_SIZE:    cfg.palette_size    <= cfg_data[PAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  mbet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_stall (pix_stall),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mbet_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (qstat)
  );

  mbet_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .qstat     (qstat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== src/mbet_checker.sv =====
// Port-level checker for the Mandelbrot escape-time pixel block, bound to the
// top level. Depends on mbet_pkg.
module mbet_checker import mbet_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     pix_valid,
  input logic                     pix_stall,
  input pix_t                     pix,
  input logic                     res_valid,
  input logic                     res_stall,
  input res_t                     res
);

  localparam int CAPACITY = QUEUE_DEPTH + 3;

  logic [3:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = pix_valid && !pix_stall;
  assign out_acc = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix))
    else $error("stalled request changed or dropped");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed or dropped");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != 4'd0)
    else $error("result without an outstanding request");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    pending == 4'(CAPACITY) |-> pix_stall)
    else $error("request taken beyond block capacity");

endmodule

bind mandelbrot_escape_time_pixel mbet_checker u_mbet_checker (.*);

// ===== verif/tb_mandelbrot_escape_time_pixel.sv =====
// Self-checking bench for mandelbrot_escape_time_pixel: directed plan, then random viewports.
// Predicts results in fixed point or takes them from the plan; compares fields in order.
// Depends on mbet_pkg and the block's RTL only.
module tb_mandelbrot_escape_time_pixel;
  import mbet_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint unsigned ESC_MAG  = 64'd2 << FRAC_BITS;
  localparam longint unsigned ESC_NORM = 64'd4 << FRAC_BITS;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_PIXELS   = 75;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 500000;

  typedef struct packed {
    logic                     is_cfg;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    pix_t                     p;
    logic                     typed;
    logic [COLOR_BITS-1:0]    color;
    logic                     in_set;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     pix_valid;
  logic                     pix_stall;
  pix_t                     pix;
  logic                     res_valid;
  logic                     res_stall;
  res_t                     res;

  longint      view_re;
  longint      view_im;
  longint      step_re;
  longint      step_im;
  int unsigned iter_limit;
  logic        angle_mode;
  int unsigned palette;

  res_t      owed_results[$];
  plan_row_t plan[$];
  res_t      want;
  int        idle_pct;
  int        fail_count;
  int        sent_count;
  int        directed_count;
  int        results_seen;
  int        view_count;
  int        hold_count;
  int        hold_left;
  int        next_hold;
  int        quiet_cycles;

  mandelbrot_escape_time_pixel dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic res_t iterate_point(input pix_t p);
    longint          cr, ci, zr, zi, term;
    longint unsigned ar, ai, r2, i2, xprod;
    int unsigned     n, color;
    logic            bounded, running;
    res_t            r;
    cr = clamp_coord(view_re + longint'(p.pixel_col) * step_re);
    ci = clamp_coord(view_im - longint'(p.pixel_row) * step_im);
    zr = cr;
    zi = ci;
    n = 0;
    bounded = 1'b1;
    running = 1'b1;
    while (running && n < iter_limit) begin
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      if (ar > ESC_MAG || ai > ESC_MAG) begin
        bounded = 1'b0;
        running = 1'b0;
      end else begin
        r2 = (ar * ar) >> FRAC_BITS;
        i2 = (ai * ai) >> FRAC_BITS;
        if (r2 + i2 > ESC_NORM) begin
          bounded = 1'b0;
          running = 1'b0;
        end else begin
          xprod = ((ar * ai) >> FRAC_BITS) << 1;
          if (xprod > COORD_HI) xprod = COORD_HI;
          term = ((zr < 0) != (zi < 0)) ? -longint'(xprod) : longint'(xprod);
          zi = clamp_coord(term + ci);
          zr = clamp_coord(clamp_coord(longint'(r2) - longint'(i2)) + cr);
          n++;
        end
      end
    end
    color = n;
    if (angle_mode) begin
      if (zr > 0 && zi > 0) color += 1;
      else if (zr <= 0 && zi > 0) color += palette >> 2;
      else if (zr <= 0 && zi < 0) color += palette >> 1;
      else color += (3 * palette) >> 2;
    end
    r.col_out = p.pixel_col;
    r.row_out = p.pixel_row;
    r.color_index = color[COLOR_BITS-1:0];
    r.in_set = bounded;
    return r;
  endfunction

  task automatic note_fail(input string why);
    fail_count++;
    if (fail_count <= 10) $display("%s", why);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ORIGIN_RE:       view_re = longint'($signed(val));
      REG_TOP_IM:          view_im = longint'($signed(val));
      REG_STEP_RE:         step_re = longint'(val[STEP_BITS-1:0]);
      REG_STEP_IM:         step_im = longint'(val[STEP_BITS-1:0]);
      REG_ITERATION_LIMIT: iter_limit = 32'(val[LIMIT_BITS-1:0]);
      REG_COLORING_MODE:   angle_mode = val[0];
      REG_PALETTE_SIZE:    palette = 32'(val[PAL_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drop the request line and wait for every owed result
  task automatic drain;
    pix_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  task automatic offer_pixel(input pix_t p, input logic typed, input res_t typed_res);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = (pix_stall === 1'b0);
      @(posedge clk);
    end
    owed_results.push_back(typed ? typed_res : iterate_point(p));
    sent_count++;
  endtask

  task automatic pick_view(input bit wild, input int unsigned max_limit);
    logic [CFG_DATA_BITS-1:0] re0, im0, sr, si;
    if (wild) begin
      re0 = $urandom;
      im0 = $urandom;
      sr = $urandom;
      si = $urandom;
    end else begin
      re0 = $urandom_range(939524096) - 671088640;
      im0 = $urandom_range(805306368) - 268435456;
      sr = $urandom_range(1 << 18, 1 << 12);
      si = $urandom_range(1 << 18, 1 << 12);
    end
    drain;
    write_reg(REG_ORIGIN_RE, re0);
    write_reg(REG_TOP_IM, im0);
    write_reg(REG_STEP_RE, sr);
    write_reg(REG_STEP_IM, si);
    write_reg(REG_ITERATION_LIMIT, $urandom_range(max_limit, 1));
    write_reg(REG_COLORING_MODE, $urandom_range(1));
    write_reg(REG_PALETTE_SIZE, $urandom_range(65535));
    cfg_we <= 1'b0;
    view_count++;
  endtask

  task automatic add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endtask

  task automatic add_pix(input int col, input int row, input logic typed,
                         input int color, input logic in_set);
    plan_row_t r;
    r = '0;
    r.p.pixel_col = PIXEL_BITS'(col);
    r.p.pixel_row = PIXEL_BITS'(row);
    r.typed = typed;
    r.color = COLOR_BITS'(color);
    r.in_set = in_set;
    plan.push_back(r);
  endtask

  // Reset view: c spans re -2..2, im 1.5..-2.5 at 1/1024 per pixel.
  task automatic build_plan;
    add_pix(0, 0, 1'b1, 0, 1'b0);
    add_pix(2048, 1536, 1'b1, 256, 1'b1);
    add_pix(4095, 4095, 1'b1, 0, 1'b0);
    add_pix(4095, 0, 1'b1, 0, 1'b0);
    add_pix(0, 4095, 1'b1, 0, 1'b0);
    add_pix(1536, 1536, 1'b0, 0, 1'b0);
    add_pix(1024, 1536, 1'b0, 0, 1'b0);
    add_pix(2304, 1536, 1'b0, 0, 1'b0);
    add_pix(1800, 1000, 1'b0, 0, 1'b0);
    add_pix(700, 1400, 1'b0, 0, 1'b0);
    // angle offsets, one per quadrant, palette 256
    add_cfg(REG_COLORING_MODE, 1);
    add_pix(2048, 1536, 1'b1, 448, 1'b1);
    add_pix(0, 0, 1'b1, 64, 1'b0);
    add_pix(4095, 0, 1'b1, 1, 1'b0);
    add_pix(0, 4095, 1'b1, 128, 1'b0);
    add_pix(4095, 4095, 1'b1, 192, 1'b0);
    add_cfg(REG_PALETTE_SIZE, 0);
    add_pix(0, 0, 1'b1, 0, 1'b0);
    add_cfg(REG_PALETTE_SIZE, 3);
    add_pix(4095, 4095, 1'b1, 2, 1'b0);
    // zero iteration limit reports in-set with count zero
    add_cfg(REG_ITERATION_LIMIT, 0);
    add_pix(0, 0, 1'b1, 0, 1'b1);
    add_cfg(REG_ITERATION_LIMIT, 1);
    add_cfg(REG_COLORING_MODE, 0);
    add_pix(2048, 1536, 1'b1, 1, 1'b1);
    // writes to the unused index must not land anywhere
    add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    add_pix(2048, 1536, 1'b1, 1, 1'b1);
    // saturated points at the coordinate extremes
    add_cfg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
    add_cfg(REG_TOP_IM, 32'h8000_0000);
    add_cfg(REG_STEP_RE, 32'h7FFF_FFFF);
    add_cfg(REG_STEP_IM, 32'h7FFF_FFFF);
    add_cfg(REG_ITERATION_LIMIT, 65535);
    add_cfg(REG_COLORING_MODE, 1);
    add_cfg(REG_PALETTE_SIZE, 65535);
    add_pix(4095, 4095, 1'b1, 49151, 1'b0);
    add_pix(0, 0, 1'b1, 49151, 1'b0);
    add_cfg(REG_ORIGIN_RE, 32'h8000_0000);
    add_cfg(REG_TOP_IM, 32'h7FFF_FFFF);
    add_pix(0, 0, 1'b1, 16383, 1'b0);
    add_pix(4095, 4095, 1'b1, 49151, 1'b0);
    // c = 0 at the largest limit and palette: widest color index
    add_cfg(REG_ORIGIN_RE, 0);
    add_cfg(REG_TOP_IM, 0);
    add_cfg(REG_STEP_RE, 0);
    add_cfg(REG_STEP_IM, 0);
    add_pix(4095, 4095, 1'b1, 114686, 1'b1);
  endtask

  // stimulus and end of run
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_valid = 1'b0;
    pix = '0;
    view_re = longint'(RST_ORIGIN_RE);
    view_im = longint'(RST_TOP_IM);
    step_re = longint'(RST_STEP);
    step_im = longint'(RST_STEP);
    iter_limit = 32'(RST_LIMIT);
    angle_mode = 1'b0;
    palette = 32'(RST_PALETTE);
    idle_pct = 35;
    fail_count = 0;
    sent_count = 0;
    view_count = 1;
    build_plan();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        cfg_we <= 1'b0;
        offer_pixel(plan[i].p, plan[i].typed,
                    res_t'({plan[i].p, plan[i].color, plan[i].in_set}));
      end
    end
    directed_count = sent_count;
    view_count += 5;
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      idle_pct = (k == 5) ? 0 : 35;
      pick_view(k % 4 == 3, (k == 7) ? 300 : 48);
      repeat (PHASE_PIXELS) offer_pixel(pix_t'((2 * PIXEL_BITS)'($urandom)), 1'b0, '0);
    end
    drain;
    repeat (32) @(posedge clk);
    $display("Checked %0d results for %0d pixel requests (%0d directed) over %0d views.",
             results_seen, sent_count, directed_count, view_count);
    $display("Receiver hold-offs: %0d; mismatches: %0d.", hold_count, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls plus long hold-offs that back the block up
  initial begin
    res_stall = 1'b0;
    hold_left = 0;
    hold_count = 0;
    next_hold = 150;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && results_seen >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold += 450;
        hold_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial results_seen = 0;

  always @(negedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        note_fail($sformatf("unexpected result: col %0d row %0d color %0d in_set %0b",
                            res.col_out, res.row_out, res.color_index, res.in_set));
      end else begin
        want = owed_results.pop_front();
        if (res.col_out !== want.col_out || res.row_out !== want.row_out ||
            res.color_index !== want.color_index || res.in_set !== want.in_set) begin
          note_fail($sformatf({"mismatch at result %0d: expected col %0d row %0d ",
                               "color %0d in_set %0b, got col %0d row %0d color %0d ",
                               "in_set %0b"},
                              results_seen, want.col_out, want.row_out,
                              want.color_index, want.in_set, res.col_out,
                              res.row_out, res.color_index, res.in_set));
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((pix_valid === 1'b1 && pix_stall === 1'b0) ||
          (res_valid === 1'b1 && res_stall === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no request or result moved for %0d cycles.", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
